### design/arpc_pkg.sv
// Shared types and constants for the ARP cache table.
// Holds the request, command and response item layouts and the opcode names.
// No dependencies.
`default_nettype none

package arpc_pkg;

    // Table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KIND_W  = 2;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 4;

    // Front-to-back command queue
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Request kinds as seen on the port
    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SRCH = 2'd2;

    // Internal operation codes after classification
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_SRCH = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IP_W-1:0]    ip_addr;
        logic [MAC_W-1:0]   mac_addr;
        logic [STAMP_W-1:0] now_time;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [MAC_W-1:0]   mac_out;
        logic               mac_changed;
    } rsp_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } cmd_t;

endpackage

`default_nettype wire

### design/arpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/arpc_front.sv
// Front end of the ARP cache: accepts request items, classifies the kind
// into an operation code and holds commands in a short queue. Uses arpc_pkg.
`default_nettype none

module arpc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire arpc_pkg::req_t req,
    output logic               cmd_valid,
    output arpc_pkg::cmd_t     cmd,
    input  wire logic          cmd_pop
);

    import arpc_pkg::*;

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              cls;
    logic              push;

    // Classify the request; drop fields an operation does not use
    always_comb
    begin
        cls    = '0;
        cls.ip = req.ip_addr;
        unique case (req.kind)
            KIND_ADD:
            begin
                cls.op    = OP_ADD;
                cls.mac   = req.mac_addr;
                cls.stamp = req.now_time;
            end
            KIND_DEL:  cls.op = OP_DEL;
            KIND_SRCH: cls.op = OP_SRCH;
            default:   cls.op = OP_NOP;
        endcase
    end

    assign req_stall = (cnt_reg == QCNT_W'(QDEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // Advance queue pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(cmd_pop && cmd_valid))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && cmd_pop && cmd_valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

### design/arpc_back.sv
// Back end of the ARP cache: walks the table one entry a cycle (an unused kind
// skips the walk), then writes back on an add and loads the response register. Uses arpc_pkg and arpc_ram.
`default_nettype none

module arpc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire arpc_pkg::cmd_t cmd,
    output logic                cmd_pop,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output arpc_pkg::rsp_t      rsp
);

    import arpc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic               chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    cmd_t               cur_reg, cur_next;
    logic [ENTRIES-1:0] occ_reg, occ_next;

    logic               match_f_reg, match_f_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [MAC_W-1:0]   match_mac_reg, match_mac_next;
    logic               empty_f_reg, empty_f_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    logic               old_f_reg, old_f_next;
    logic [IDX_W-1:0]   old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0] old_stamp_reg, old_stamp_next;

    logic               out_full_reg, out_full_next;
    rsp_t               out_reg, out_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [IP_W-1:0]    ip_rd;
    logic [MAC_W-1:0]   mac_rd;
    logic [STAMP_W-1:0] stamp_rd;
    logic [IDX_W-1:0]   add_idx;
    logic               out_free;

    // Table stores
    arpc_ram #(.WIDTH(IP_W), .DEPTH(ENTRIES)) u_ip_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cur_reg.ip),
        .raddr (ram_raddr),
        .rdata (ip_rd)
    );

    arpc_ram #(.WIDTH(MAC_W), .DEPTH(ENTRIES)) u_mac_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cur_reg.mac),
        .raddr (ram_raddr),
        .rdata (mac_rd)
    );

    arpc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cur_reg.stamp),
        .raddr (ram_raddr),
        .rdata (stamp_rd)
    );

    assign ram_raddr = rd_cnt_reg[IDX_W-1:0];
    assign rsp_valid = out_full_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_full_reg || !rsp_stall;
    assign add_idx   = match_f_reg ? match_idx_reg :
                       (empty_f_reg ? empty_idx_reg : old_idx_reg);

    // Walk, write back and respond
    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        chk_vld_next   = 1'b0;
        chk_idx_next   = chk_idx_reg;
        cur_next       = cur_reg;
        occ_next       = occ_reg;
        match_f_next   = match_f_reg;
        match_idx_next = match_idx_reg;
        match_mac_next = match_mac_reg;
        empty_f_next   = empty_f_reg;
        empty_idx_next = empty_idx_reg;
        old_f_next     = old_f_reg;
        old_idx_next   = old_idx_reg;
        old_stamp_next = old_stamp_reg;
        out_full_next  = out_full_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = add_idx;
        cmd_pop        = 1'b0;

        // Drop the response once taken
        if (out_full_reg && !rsp_stall)
        begin
            out_full_next = 1'b0;
        end

        // Examine the entry read in the previous cycle
        if (chk_vld_reg)
        begin
            if (occ_reg[chk_idx_reg])
            begin
                if (!match_f_reg && ip_rd == cur_reg.ip)
                begin
                    match_f_next   = 1'b1;
                    match_idx_next = chk_idx_reg;
                    match_mac_next = mac_rd;
                end
                if (!old_f_reg || stamp_rd < old_stamp_reg)
                begin
                    old_f_next     = 1'b1;
                    old_idx_next   = chk_idx_reg;
                    old_stamp_next = stamp_rd;
                end
            end
            else if (!empty_f_reg)
            begin
                empty_f_next   = 1'b1;
                empty_idx_next = chk_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    cur_next     = cmd;
                    rd_cnt_next  = '0;
                    match_f_next = 1'b0;
                    empty_f_next = 1'b0;
                    old_f_next   = 1'b0;
                    state_next   = (cmd.op == OP_NOP) ? ST_FIN : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (rd_cnt_reg == CNT_W'(ENTRIES))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_full_next = 1'b1;
                    out_next      = '0;
                    state_next    = ST_IDLE;
                    case (cur_reg.op)
                        OP_ADD:
                        begin
                            ram_we            = 1'b1;
                            occ_next[add_idx] = (cur_reg.mac != '0);
                            out_next.hit      = 1'b1;
                            out_next.slot     = SLOT_W'(add_idx);
                            out_next.mac_changed =
                                match_f_reg && (match_mac_reg != cur_reg.mac);
                        end
                        OP_DEL:
                        begin
                            if (match_f_reg)
                            begin
                                occ_next[match_idx_reg] = 1'b0;
                                out_next.hit  = 1'b1;
                                out_next.slot = SLOT_W'(match_idx_reg);
                            end
                        end
                        OP_SRCH:
                        begin
                            if (match_f_reg)
                            begin
                                out_next.hit     = 1'b1;
                                out_next.slot    = SLOT_W'(match_idx_reg);
                                out_next.mac_out = match_mac_reg;
                            end
                        end
                        default:
                        begin
                            out_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            chk_vld_reg  <= 1'b0;
            occ_reg      <= '0;
            match_f_reg  <= 1'b0;
            empty_f_reg  <= 1'b0;
            old_f_reg    <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            chk_vld_reg  <= chk_vld_next;
            occ_reg      <= occ_next;
            match_f_reg  <= match_f_next;
            empty_f_reg  <= empty_f_next;
            old_f_reg    <= old_f_next;
            out_full_reg <= out_full_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        cur_reg       <= cur_next;
        match_idx_reg <= match_idx_next;
        match_mac_reg <= match_mac_next;
        empty_idx_reg <= empty_idx_next;
        old_idx_reg   <= old_idx_next;
        old_stamp_reg <= old_stamp_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

### design/arp_cache_table_core.sv
// ARP cache table core: IPv4-to-MAC cache with oldest-entry replacement.
// An add, delete or search holds the back end through these steps: take it
// from the queue, one RAM read per entry, finish the compare, write back; an
// unused kind skips the walk. The single RAM read port is why each entry is
// read in turn. The response is valid the cycle after write-back. Reset
// empties the table at once via occupancy flops.
`default_nettype none

module arp_cache_table_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire arpc_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output arpc_pkg::rsp_t      rsp
);

    import arpc_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    arpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    arpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // A miss carries no slot, MAC or change flag
    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.hit) |-> (rsp.slot == '0 && rsp.mac_out == '0
                                     && !rsp.mac_changed))
        else $error("miss response carries nonzero fields");

    // A change flag only comes from an add, which never returns a MAC
    a_changed_add : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.mac_changed) |-> (rsp.hit && rsp.mac_out == '0))
        else $error("mac_changed set on a non-add response");

    // The queue never pops while it holds no commands
    a_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire
